/* rtl/frv_pkg.sv */
// Shared types, codes and constants of the fragment run validator.
// No dependencies; imported by every module of the block.
package frv_pkg;

    localparam int HEADER_BYTES   = 12;
    localparam int COMP_HDR_BYTES = HEADER_BYTES + 4;
    localparam int FIFO_DEPTH     = 4;

    localparam int SIZE_W  = 12;
    localparam int SEQ_W   = 16;
    localparam int FLAG_W  = 8;
    localparam int COUNT_W = 16;
    localparam int USIZE_W = 32;
    localparam int VERD_W  = 3;
    localparam int DROP_W  = 16;
    localparam int MSG_W   = 25;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [VERD_W-1:0] V_ACCEPT     = 3'd0;
    localparam logic [VERD_W-1:0] V_META       = 3'd1;
    localparam logic [VERD_W-1:0] V_ORPHAN     = 3'd2;
    localparam logic [VERD_W-1:0] V_COMPRESSED = 3'd3;
    localparam logic [VERD_W-1:0] V_ABSURD     = 3'd4;
    localparam logic [VERD_W-1:0] V_BROKEN     = 3'd5;

    localparam int FLAG_DEFLATED   = 0;
    localparam int FLAG_FIRST      = 1;
    localparam int FLAG_COMPRESSED = 2;
    localparam int FLAG_HIGH_PRIO  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_HIGH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNCOMP_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAGS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MSG      = 2'd3;

    localparam logic [USIZE_W-1:0] RST_UNCOMP_LIMIT = 32'd20971520;
    localparam logic [COUNT_W-1:0] RST_MAX_FRAGS    = 16'd22122;
    localparam logic [MSG_W-1:0]   RST_MAX_MSG      = 25'd20971532;

    typedef struct packed {
        logic               queue_high;
        logic [USIZE_W-1:0] uncompressed_limit;
        logic [COUNT_W-1:0] max_fragments;
        logic [MSG_W-1:0]   max_message_size;
    } frv_cfg_t;

    typedef struct packed {
        logic               owner_ok;
        logic [SIZE_W-1:0]  frame_size;
        logic [SEQ_W-1:0]   seq_num;
        logic [FLAG_W-1:0]  flag_byte;
        logic [COUNT_W-1:0] packet_count;
        logic [USIZE_W-1:0] uncompressed_size;
    } frv_item_t;

    typedef struct packed {
        logic [VERD_W-1:0] verdict;
        logic [DROP_W-1:0] frames_dropped;
        logic [MSG_W-1:0]  message_size;
    } frv_result_t;

    typedef struct packed {
        logic [1:0]  count;
        frv_result_t first;
        frv_result_t second;
    } frv_push_t;

endpackage

/* rtl/fragment_run_validator.sv */
// Fragment run validator: checks queued frame headers and reports verdicts.
// Depends on frv_pkg, frv_check and frv_fifo.
//
// Usage: one frame header per s_ transfer; verdicts leave on the m_ channel,
// the verdict code in m_tuser and the dropped count and message size in
// m_tdata. A frame gives zero, one or two verdicts: a fragment that continues
// an open run gives none until the run completes; a frame that breaks a run
// gives the run-broken verdict, then its head verdict unless it opens a run.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data,
// one per cycle, while no frame is in flight.
// A frame is held in the input register, then the check logic writes its
// verdicts into the result queue, whose head entry drives m_tvalid and the
// result channel.
// Throughput: one frame per cycle; the input register advances whenever the
// result queue has room for two verdicts.
// When the receiver stalls, results collect in the result queue and s_tready
// drops once the queue cannot take two more.
// Reset (aresetn low, synchronous) closes any open run, empties the queue
// and loads the register defaults.
module fragment_run_validator #(
    parameter int FIFO_DEPTH = frv_pkg::FIFO_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // owner_ok, frame_size, seq_num, packet_count, uncompressed_size
    input  logic [frv_pkg::S_TDATA_W-1:0]     s_tdata,
    // flag_byte
    input  logic [frv_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // frames_dropped, message_size
    output logic [frv_pkg::M_TDATA_W-1:0]     m_tdata,
    // verdict
    output logic [frv_pkg::M_TUSER_W-1:0]     m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [frv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [frv_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import frv_pkg::*;

    frv_cfg_t    cfg_reg;
    logic        in_valid_reg;
    frv_item_t   item_reg, item_next;
    logic        advance;
    logic        has_room;
    frv_push_t   push;
    frv_result_t out_res;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && has_room;
    assign s_tready  = !in_valid_reg || advance;

    assign item_next.owner_ok          = s_tdata[0];
    assign item_next.frame_size        = s_tdata[12:1];
    assign item_next.seq_num           = s_tdata[28:13];
    assign item_next.flag_byte         = s_tuser;
    assign item_next.packet_count      = s_tdata[44:29];
    assign item_next.uncompressed_size = s_tdata[76:45];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.queue_high         <= 1'b0;
            cfg_reg.uncompressed_limit <= RST_UNCOMP_LIMIT;
            cfg_reg.max_fragments      <= RST_MAX_FRAGS;
            cfg_reg.max_message_size   <= RST_MAX_MSG;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_QUEUE_HIGH:   cfg_reg.queue_high         <= cfg_data[0];
                REG_UNCOMP_LIMIT: cfg_reg.uncompressed_limit <= cfg_data[USIZE_W-1:0];
                REG_MAX_FRAGS:    cfg_reg.max_fragments      <= cfg_data[COUNT_W-1:0];
                REG_MAX_MSG:      cfg_reg.max_message_size   <= cfg_data[MSG_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    frv_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .push       (push)
    );

    frv_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {(M_TDATA_W - DROP_W - MSG_W)'(0), out_res.message_size,
                      out_res.frames_dropped};
    assign m_tuser = out_res.verdict;

`ifndef NO_ASSERTIONS
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && !has_room)
        else $error("input stalled without a waiting frame");
`endif

endmodule

/* rtl/frv_check.sv */
// Header checks and fragment run state of the fragment run validator.
// Depends on frv_pkg; produces up to two results per transfer.
module frv_check (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  frv_pkg::frv_item_t item,
    input  frv_pkg::frv_cfg_t  cfg,
    output frv_pkg::frv_push_t push
);
    import frv_pkg::*;

    logic               run_open_reg, run_open_next;
    logic [COUNT_W-1:0] run_needed_reg, run_needed_next;
    logic [COUNT_W-1:0] run_seen_reg, run_seen_next;
    logic [SEQ_W-1:0]   prev_seq_reg, prev_seq_next;
    logic [MSG_W-1:0]   run_bytes_reg, run_bytes_next;

    logic               meta_ok;
    logic [SIZE_W-1:0]  body_bytes;
    logic [MSG_W:0]     total;
    logic               cont_ok;
    logic [COUNT_W-1:0] seen_inc;
    logic               run_done;
    logic               comp_bad;
    logic               head_emit;
    logic               head_open;
    frv_result_t        head_res;
    frv_result_t        accept_res;
    frv_result_t        broken_res;

    assign meta_ok = (item.frame_size >= SIZE_W'(HEADER_BYTES)) && item.owner_ok
                     && (item.flag_byte[FLAG_HIGH_PRIO] == cfg.queue_high);
    assign body_bytes = item.frame_size - SIZE_W'(HEADER_BYTES);
    assign total      = {1'b0, run_bytes_reg} + (MSG_W+1)'(body_bytes);
    assign cont_ok    = meta_ok
                        && (item.seq_num == prev_seq_reg + SEQ_W'(1))
                        && !item.flag_byte[FLAG_DEFLATED]
                        && !item.flag_byte[FLAG_FIRST]
                        && !item.flag_byte[FLAG_COMPRESSED]
                        && (item.packet_count == '0)
                        && (total <= {1'b0, cfg.max_message_size});
    assign seen_inc   = run_seen_reg + COUNT_W'(1);
    assign run_done   = seen_inc >= run_needed_reg;
    assign comp_bad   = item.flag_byte[FLAG_COMPRESSED]
                        && ((item.frame_size < SIZE_W'(COMP_HDR_BYTES))
                            || (item.uncompressed_size > cfg.uncompressed_limit));

    always_comb begin
        head_emit = 1'b1;
        head_open = 1'b0;
        head_res  = '{verdict: V_ACCEPT, frames_dropped: DROP_W'(1), message_size: '0};
        if (!meta_ok) begin
            head_res.verdict = V_META;
        end else if (!item.flag_byte[FLAG_FIRST] || item.packet_count == '0) begin
            head_res.verdict = V_ORPHAN;
        end else if (comp_bad) begin
            head_res.verdict = V_COMPRESSED;
        end else if (item.packet_count == COUNT_W'(1)) begin
            head_res.message_size = MSG_W'(item.frame_size);
        end else if (item.packet_count > cfg.max_fragments) begin
            head_res.verdict = V_ABSURD;
        end else begin
            head_emit = 1'b0;
            head_open = 1'b1;
        end
    end

    assign accept_res = '{verdict: V_ACCEPT, frames_dropped: run_needed_reg,
                          message_size: total[MSG_W-1:0]};
    assign broken_res = '{verdict: V_BROKEN, frames_dropped: run_seen_reg,
                          message_size: '0};

    always_comb begin
        run_open_next   = run_open_reg;
        run_needed_next = run_needed_reg;
        run_seen_next   = run_seen_reg;
        prev_seq_next   = prev_seq_reg;
        run_bytes_next  = run_bytes_reg;
        push.count      = 2'd0;
        push.first      = head_res;
        push.second     = head_res;
        if (item_valid) begin
            if (run_open_reg && cont_ok) begin
                prev_seq_next = item.seq_num;
                if (run_done) begin
                    push.count      = 2'd1;
                    push.first      = accept_res;
                    run_open_next   = 1'b0;
                    run_needed_next = '0;
                    run_seen_next   = '0;
                    run_bytes_next  = '0;
                end else begin
                    run_seen_next  = seen_inc;
                    run_bytes_next = total[MSG_W-1:0];
                end
            end else begin
                if (run_open_reg) begin
                    push.first = broken_res;
                    push.count = head_emit ? 2'd2 : 2'd1;
                end else begin
                    push.count = head_emit ? 2'd1 : 2'd0;
                end
                if (head_open) begin
                    run_open_next   = 1'b1;
                    run_needed_next = item.packet_count;
                    run_seen_next   = COUNT_W'(1);
                    prev_seq_next   = item.seq_num;
                    run_bytes_next  = MSG_W'(item.frame_size);
                end else begin
                    run_open_next   = 1'b0;
                    run_needed_next = '0;
                    run_seen_next   = '0;
                    run_bytes_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg   <= 1'b0;
            run_needed_reg <= '0;
            run_seen_reg   <= '0;
            prev_seq_reg   <= '0;
            run_bytes_reg  <= '0;
        end else begin
            run_open_reg   <= run_open_next;
            run_needed_reg <= run_needed_next;
            run_seen_reg   <= run_seen_next;
            prev_seq_reg   <= prev_seq_next;
            run_bytes_reg  <= run_bytes_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_open_count: assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg |-> (run_seen_reg != '0) && (run_seen_reg < run_needed_reg))
        else $error("open run with inconsistent fragment count");
    a_closed_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_open_reg |-> (run_seen_reg == '0) && (run_bytes_reg == '0))
        else $error("closed run keeps fragment state");
`endif

endmodule

/* rtl/frv_fifo.sv */
// Result queue of the fragment run validator: takes up to two results per cycle.
// Depends on frv_pkg; drives the result channel from its head entry.
module frv_fifo #(
    parameter int DEPTH = frv_pkg::FIFO_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  frv_pkg::frv_push_t push,
    output logic               has_room,
    output logic               out_valid,
    input  logic               out_ready,
    output frv_pkg::frv_result_t out_res
);
    import frv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frv_result_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_p1, wr_ptr_p2;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);
    assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);
    assign out_valid = count_reg != '0;
    assign pop       = out_valid && out_ready;
    assign out_res   = mem_reg[rd_ptr_reg];
    assign has_room  = count_reg <= CNT_W'(DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = wr_ptr_p2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> has_room)
        else $error("results pushed without room");
`endif

endmodule
